// ===== rtl/sicrt_pkg.sv =====
// Shared types and constants for the signed integer to custom radix text block.
`default_nettype none
package sicrt_pkg;

    localparam int MAG_W        = 32;
    localparam int CHAR_W       = 8;
    localparam int SYMBOLS      = 16;
    localparam int ALPHABET_MAX = 16;
    localparam int DIGIT_W      = 4;
    localparam int REM_W        = DIGIT_W;
    localparam int RADIX_W      = 5;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_BITS    = 8;
    localparam int STEP_COUNT   = MAG_W / STEP_BITS;
    localparam int STEP_W       = $clog2(STEP_COUNT);
    localparam int STACK_DEPTH  = MAG_W;
    localparam int COUNT_W      = $clog2(STACK_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;

    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/sicrt_divstep.sv =====
// Radix divider slice: eight restoring long-division bits of the magnitude per cycle.
`default_nettype none
module sicrt_divstep (
    input  wire logic [sicrt_pkg::MAG_W-1:0]   i_work,
    input  wire logic [sicrt_pkg::REM_W-1:0]   i_rem,
    input  wire logic [sicrt_pkg::RADIX_W-1:0] i_radix,
    output logic      [sicrt_pkg::MAG_W-1:0]   o_work,
    output logic      [sicrt_pkg::REM_W-1:0]   o_rem
);

    localparam int MAG_W     = sicrt_pkg::MAG_W;
    localparam int REM_W     = sicrt_pkg::REM_W;
    localparam int STEP_BITS = sicrt_pkg::STEP_BITS;

    logic [REM_W:0]         v_acc;
    logic [REM_W-1:0]       v_rem;
    logic [STEP_BITS-1:0]   v_q;

    always_comb begin
        v_rem = i_rem;
        v_acc = '0;
        v_q   = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            v_acc = {v_rem, i_work[MAG_W-1-k]};
            if (v_acc >= i_radix) begin
                v_q[STEP_BITS-1-k] = 1'b1;
                v_acc = v_acc - i_radix;
            end
            v_rem = v_acc[REM_W-1:0];
        end
        o_work = {i_work[MAG_W-STEP_BITS-1:0], v_q};
        o_rem  = v_rem;
    end

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_custom_radix_text_top.sv =====
// Top level: signed 32-bit number to text in the radix of a configured alphabet.
// Each number is taken when o_in_ready is high, i.e. while the block is idle. The magnitude is
// divided by the radix on a shared divider slice that handles 8 dividend bits per cycle, and the
// digits are stacked; the block is then busy until the characters have been output (one
// character per cycle with the output ready). An invalid alphabet releases the number with no
// characters. The last output beat of a number can still be waiting in the output register while
// the next number is accepted.
`default_nettype none
module signed_int_to_custom_radix_text_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sicrt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sicrt_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [sicrt_pkg::MAG_W-1:0]  i_number,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [sicrt_pkg::CHAR_W-1:0]        o_character,
    output logic                                     o_is_last
);

    localparam int MAG_W       = sicrt_pkg::MAG_W;
    localparam int CHAR_W      = sicrt_pkg::CHAR_W;
    localparam int SYMBOLS     = sicrt_pkg::SYMBOLS;
    localparam int DIGIT_W     = sicrt_pkg::DIGIT_W;
    localparam int RADIX_W     = sicrt_pkg::RADIX_W;
    localparam int CFG_W       = sicrt_pkg::CFG_W;
    localparam int STEP_W      = sicrt_pkg::STEP_W;
    localparam int STACK_DEPTH = sicrt_pkg::STACK_DEPTH;
    localparam int COUNT_W     = sicrt_pkg::COUNT_W;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(sicrt_pkg::STEP_COUNT - 1);

    sicrt_pkg::t_state r_state, n_state;

    logic [CFG_W-1:0]    r_digits_low;
    logic [CFG_W-1:0]    r_digits_high;
    logic [RADIX_W-1:0]  r_digit_count;
    logic                r_alpha_ok;

    logic                r_neg;
    logic [MAG_W-1:0]    r_work;
    logic [DIGIT_W-1:0]  r_rem;
    logic [STEP_W-1:0]   r_step;
    logic [COUNT_W-1:0]  r_count;
    logic [DIGIT_W-1:0]  r_stack [STACK_DEPTH];

    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    logic [2*CFG_W-1:0]  w_alpha;
    logic [CHAR_W-1:0]   w_sym;
    logic [MAG_W-1:0]    w_raw;
    logic [MAG_W-1:0]    w_mag;
    logic [MAG_W-1:0]    w_div_work;
    logic [DIGIT_W-1:0]  w_div_rem;
    logic                w_in_fire;
    logic                w_out_free;
    logic                w_load;
    logic [CHAR_W-1:0]   w_load_char;
    logic                w_load_last;
    logic                w_push;
    logic                w_pop;
    logic                v_ok;
    logic [CHAR_W-1:0]   v_sym;

    assign w_alpha   = {r_digits_high, r_digits_low};
    assign w_sym     = w_alpha[{r_stack[0], 3'b000} +: CHAR_W];
    assign w_raw     = i_number;
    assign w_mag     = w_raw[MAG_W-1] ? ('0 - w_raw) : w_raw;
    assign w_in_fire = i_in_valid && o_in_ready;

    assign o_in_ready  = (r_state == sicrt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_is_last   = r_last;

    sicrt_divstep u_divstep (
        .i_work  (r_work),
        .i_rem   (r_rem),
        .i_radix (r_digit_count),
        .o_work  (w_div_work),
        .o_rem   (w_div_rem)
    );

    // alphabet check, registered; the user must keep config changes to while idle, the block does not enforce it
    always_comb begin
        v_ok  = (r_digit_count >= RADIX_W'(2))
             && (r_digit_count <= RADIX_W'(sicrt_pkg::ALPHABET_MAX));
        v_sym = '0;
        for (int i = 0; i < SYMBOLS; i++) begin
            v_sym = w_alpha[i*CHAR_W +: CHAR_W];
            if (RADIX_W'(i) < r_digit_count) begin
                if (v_sym == sicrt_pkg::CHAR_PLUS || v_sym == sicrt_pkg::CHAR_MINUS
                    || v_sym <= sicrt_pkg::CHAR_SPACE || v_sym >= sicrt_pkg::CHAR_DEL) begin
                    v_ok = 1'b0;
                end
                for (int j = i + 1; j < SYMBOLS; j++) begin
                    if (RADIX_W'(j) < r_digit_count
                        && w_alpha[j*CHAR_W +: CHAR_W] == v_sym) begin
                        v_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sicrt_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_state = sicrt_pkg::S_CHECK;
                end
            end
            sicrt_pkg::S_CHECK: begin
                n_state = r_alpha_ok ? sicrt_pkg::S_DIV : sicrt_pkg::S_IDLE;
            end
            sicrt_pkg::S_DIV: begin
                if (w_push && w_div_work == '0) begin
                    n_state = r_neg ? sicrt_pkg::S_SIGN : sicrt_pkg::S_EMIT;
                end
            end
            sicrt_pkg::S_SIGN: begin
                if (w_out_free) begin
                    n_state = sicrt_pkg::S_EMIT;
                end
            end
            sicrt_pkg::S_EMIT: begin
                if (w_out_free && w_load_last) begin
                    n_state = sicrt_pkg::S_IDLE;
                end
            end
            default: n_state = sicrt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_out_free  = !r_out_valid || i_out_ready;
        w_load      = 1'b0;
        w_load_char = w_sym;
        w_load_last = 1'b0;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        unique case (r_state)
            sicrt_pkg::S_DIV: begin
                w_push = (r_step == STEP_LAST);
            end
            sicrt_pkg::S_SIGN: begin
                w_load      = w_out_free;
                w_load_char = sicrt_pkg::CHAR_MINUS;
            end
            sicrt_pkg::S_EMIT: begin
                w_load      = w_out_free;
                w_load_last = (r_count == COUNT_W'(1));
                w_pop       = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sicrt_pkg::S_IDLE;
            r_out_valid   <= 1'b0;
            r_count       <= '0;
            r_digits_low  <= '0;
            r_digits_high <= '0;
            r_digit_count <= '0;
            r_alpha_ok    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_alpha_ok <= v_ok;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_fire) begin
                r_count <= '0;
            end else if (w_push) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (w_pop) begin
                r_count <= r_count - COUNT_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sicrt_pkg::REG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                    sicrt_pkg::REG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                    sicrt_pkg::REG_DIGIT_COUNT: r_digit_count <= i_cfg_data[RADIX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_neg  <= w_raw[MAG_W-1];
            r_work <= w_mag;
        end
        if (r_state == sicrt_pkg::S_CHECK) begin
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == sicrt_pkg::S_DIV) begin
            r_work <= w_div_work;
            r_step <= r_step + STEP_W'(1);
            r_rem  <= w_push ? '0 : w_div_rem;
        end
        if (w_push) begin
            for (int i = STACK_DEPTH - 1; i > 0; i--) begin
                r_stack[i] <= r_stack[i-1];
            end
            r_stack[0] <= w_div_rem;
        end else if (w_pop) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
        if (w_load) begin
            r_char <= w_load_char;
            r_last <= w_load_last;
        end
    end

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sicrt_pkg::S_DIV |-> r_rem < r_digit_count)
        else $error("remainder not below radix");
    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sicrt_pkg::S_EMIT |-> r_count != '0)
        else $error("emit with empty digit stack");
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_load_last |=> r_state == sicrt_pkg::S_IDLE && r_count == '0)
        else $error("last beat did not end the number");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(STACK_DEPTH))
        else $error("digit count overflow");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for signed_int_to_custom_radix_text_top: directed table, then randomized alphabets.
module tb_top;
    import sicrt_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 200;
    localparam int RANDOM_ITEMS   = 370;
    localparam int QUIET_FROM     = 315;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    // "01234567" / "89ABCDEF", symbol k in byte k
    localparam logic [CFG_W-1:0] ALPHA_LOW  = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] ALPHA_HIGH = 64'h4645444342413938;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_beat;

    typedef enum logic {ROW_WRITE, ROW_NUMBER} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
        logic [MAG_W-1:0]     number;
        bit                   typed;
        string                text;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [MAG_W-1:0] i_number;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [CHAR_W-1:0]      o_character;
    logic                   o_is_last;

    logic [CFG_W-1:0]   alpha_low;
    logic [CFG_W-1:0]   alpha_high;
    logic [RADIX_W-1:0] alpha_size;

    t_char_beat pending_chars[$];
    t_row       directed_rows[$];
    int         mismatch_count;
    bit         quiet;
    bit         hold_req;

    signed_int_to_custom_radix_text_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_number    (i_number),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_character (o_character),
        .o_is_last   (o_is_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [CHAR_W-1:0] symbol_of(int k);
        if (k < 8) begin
            return alpha_low[k*8 +: 8];
        end
        return alpha_high[(k-8)*8 +: 8];
    endfunction

    function automatic bit alphabet_usable();
        int n;
        logic [CHAR_W-1:0] c;
        n = alpha_size;
        if (n < 2 || n > ALPHABET_MAX) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            c = symbol_of(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CHAR_SPACE || c >= CHAR_DEL) begin
                return 1'b0;
            end
            for (int j = i + 1; j < n; j++) begin
                if (symbol_of(j) == c) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Queue the characters that the current alphabet produces for one number.
    function automatic void spell_number(logic [MAG_W-1:0] raw);
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] radix;
        int digits[$];
        if (!alphabet_usable()) begin
            return;
        end
        radix = {{(MAG_W-RADIX_W){1'b0}}, alpha_size};
        mag = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
        do begin
            digits.push_front(int'(mag % radix));
            mag = mag / radix;
        end while (mag != 0);
        if (raw[MAG_W-1]) begin
            pending_chars.push_back('{CHAR_MINUS, 1'b0});
        end
        foreach (digits[i]) begin
            pending_chars.push_back('{symbol_of(digits[i]), i == digits.size() - 1});
        end
    endfunction

    function automatic void num_row(logic [MAG_W-1:0] n, bit typed, string text);
        directed_rows.push_back('{ROW_NUMBER, REG_NONE, '0, n, typed, text});
    endfunction

    function automatic void write_row(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        directed_rows.push_back('{ROW_WRITE, index, data, '0, 1'b0, ""});
    endfunction

    function automatic logic [MAG_W-1:0] random_number();
        logic [MAG_W-1:0] n;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: n = 32'h80000000;
                    1: n = 32'h7FFFFFFF;
                    2: n = 32'h00000000;
                    default: n = 32'hFFFFFFFF;
                endcase
            end
            1, 2: begin
                n = $urandom_range(0, 300);
                if ($urandom_range(0, 1) == 1) begin
                    n = ~n + 1'b1;
                end
            end
            default: n = $urandom;
        endcase
        return n;
    endfunction

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            REG_DIGITS_LOW:  alpha_low  = data;
            REG_DIGITS_HIGH: alpha_high = data;
            REG_DIGIT_COUNT: alpha_size = data[RADIX_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_number(logic [MAG_W-1:0] n, bit typed, string text);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_number   <= n;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (typed) begin
            for (int i = 0; i < text.len(); i++) begin
                pending_chars.push_back('{text[i], i == text.len() - 1});
            end
        end else begin
            spell_number(n);
        end
    endtask

    task automatic sender_gap();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    task automatic pick_alphabet(bit allow_bad);
        logic [CHAR_W-1:0] sym [SYMBOLS];
        logic [CFG_W-1:0]  lo;
        logic [CFG_W-1:0]  hi;
        logic [CFG_W-1:0]  size_word;
        logic [CHAR_W-1:0] c;
        int n;
        int k;
        bit taken;
        n = $urandom_range(2, ALPHABET_MAX);
        for (int i = 0; i < SYMBOLS; i++) begin
            if (i < n) begin
                do begin
                    c = $urandom_range(33, 126);
                    taken = (c == CHAR_PLUS) || (c == CHAR_MINUS);
                    for (int j = 0; j < i; j++) begin
                        if (sym[j] == c) begin
                            taken = 1'b1;
                        end
                    end
                end while (taken);
                sym[i] = c;
            end else begin
                sym[i] = $urandom_range(0, 255);
            end
        end
        if (allow_bad && $urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    k = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 3))
                        0: sym[k] = CHAR_PLUS;
                        1: sym[k] = CHAR_MINUS;
                        2: sym[k] = $urandom_range(0, 32);
                        default: sym[k] = $urandom_range(127, 255);
                    endcase
                end
                1: begin
                    k = $urandom_range(1, n - 1);
                    sym[k] = sym[$urandom_range(0, k - 1)];
                end
                default: n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                         : $urandom_range(17, 31);
            endcase
        end
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = sym[i];
            hi[i*8 +: 8] = sym[i+8];
        end
        size_word = {$urandom, $urandom};
        size_word[RADIX_W-1:0] = n[RADIX_W-1:0];
        drain();
        write_reg(REG_DIGITS_LOW, lo);
        write_reg(REG_DIGITS_HIGH, hi);
        write_reg(REG_DIGIT_COUNT, size_word);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int hold_len;
        i_out_ready = 1'b0;
        hold_len = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                hold_len--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_len = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold_len = $urandom_range(0, 11);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected beat: character=%0d is_last=%0b", o_character, o_is_last);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.ch) begin
                    $error("character: expected %0d, got %0d", want.ch, o_character);
                    mismatch_count++;
                end
                if (o_is_last !== want.last) begin
                    $error("is_last: expected %0b, got %0b", want.last, o_is_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int stalled;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stalled = 0;
        end else begin
            stalled++;
        end
        if (stalled >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int sent_random;
        int phase;
        int burst;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_number    = '0;
        alpha_low   = '0;
        alpha_high  = '0;
        alpha_size  = '0;
        mismatch_count = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;

        // empty alphabet after reset
        num_row(32'd5, 1'b1, "");
        write_row(REG_DIGITS_LOW, ALPHA_LOW);
        write_row(REG_DIGITS_HIGH, ALPHA_HIGH);
        write_row(REG_DIGIT_COUNT, 64'd10);
        num_row(32'd0, 1'b1, "0");
        num_row(32'h80000000, 1'b1, "-2147483648");
        num_row(32'h7FFFFFFF, 1'b1, "2147483647");
        num_row(32'hFFFFFFFF, 1'b1, "-1");
        num_row(32'd12345, 1'b0, "");
        num_row(-32'sd9876, 1'b0, "");
        write_row(REG_DIGIT_COUNT, 64'd16);
        num_row(32'h7FFFFFFF, 1'b1, "7FFFFFFF");
        num_row(32'h80000000, 1'b1, "-80000000");
        num_row(32'hDEADBEEF, 1'b0, "");
        write_row(REG_DIGIT_COUNT, 64'd2);
        num_row(32'd5, 1'b1, "101");
        num_row(32'h80000000, 1'b0, "");
        num_row(32'h7FFFFFFF, 1'b0, "");
        // write to an unused index must change nothing
        write_row(REG_NONE, 64'd0);
        num_row(32'd6, 1'b1, "110");
        write_row(REG_DIGIT_COUNT, 64'd1);
        num_row(32'd5, 1'b1, "");
        // only the low 5 bits count: 17 is above the limit
        write_row(REG_DIGIT_COUNT, 64'hFFFFFFFF_FFFFFFF1);
        num_row(32'd5, 1'b1, "");
        write_row(REG_DIGIT_COUNT, 64'd10);
        write_row(REG_DIGITS_LOW, 64'h3736353433323030);   // repeated symbol
        num_row(32'd7, 1'b1, "");
        write_row(REG_DIGITS_LOW, 64'h373635342B323130);   // plus sign
        num_row(32'd7, 1'b1, "");
        write_row(REG_DIGITS_LOW, 64'h3736353433323120);   // space
        num_row(32'd7, 1'b1, "");
        write_row(REG_DIGITS_LOW, 64'h0136353433323130);   // control char
        num_row(32'd7, 1'b1, "");
        write_row(REG_DIGITS_LOW, 64'h3736803433323130);   // high byte
        num_row(32'd7, 1'b1, "");
        write_row(REG_DIGITS_LOW, ALPHA_LOW);
        write_row(REG_DIGITS_HIGH, 64'h4645444342412D38);  // minus sign as symbol 9
        num_row(32'd7, 1'b1, "");
        write_row(REG_DIGITS_HIGH, 64'h464544434241397F);  // DEL as symbol 8
        num_row(32'd7, 1'b1, "");
        write_row(REG_DIGITS_HIGH, ALPHA_HIGH);
        num_row(-32'sd42, 1'b0, "");

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                drain();
                write_reg(directed_rows[r].index, directed_rows[r].data);
            end else begin
                send_number(directed_rows[r].number, directed_rows[r].typed,
                            directed_rows[r].text);
            end
        end

        sent_random = 0;
        phase = 0;
        while (sent_random < RANDOM_ITEMS) begin
            pick_alphabet(phase != 1);
            quiet = (sent_random >= QUIET_FROM) || ($urandom_range(0, 3) == 0);
            if (phase == 1) begin
                quiet = 1'b1;
                hold_req = 1'b1;
            end
            burst = $urandom_range(8, 30);
            repeat (burst) begin
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    sender_gap();
                end
                if (!quiet && $urandom_range(0, 39) == 0) begin
                    drain();
                end
                send_number(random_number(), 1'b0, "");
                sent_random++;
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $error("%0d expected beats never arrived", pending_chars.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
